@@ rtl/khcr_pkg.sv @@
package khcr_pkg;

	typedef enum logic [2:0] {
		MODE_NORMAL     = 3'd0,
		MODE_WAIT_RESET = 3'd1,
		MODE_WAIT_ID    = 3'd2,
		MODE_WAIT_ID1   = 3'd3,
		MODE_SCAN_SET   = 3'd4,
		MODE_SCAN_REPLY = 3'd5,
		MODE_WAIT_LEDS  = 3'd6,
		MODE_WAIT_AUTO  = 3'd7
	} mode_t;

	localparam logic       REQ_HOST_BYTE = 1'b0;
	localparam logic       REQ_TX_SLOT   = 1'b1;

	localparam logic [7:0] CMD_ECHO      = 8'hEE;
	localparam logic [7:0] CMD_READ_ID   = 8'hF2;
	localparam logic [7:0] CMD_RESET     = 8'hFF;
	localparam logic [7:0] CMD_RESEND    = 8'hFE;
	localparam logic [7:0] CMD_SCAN_SET  = 8'hF0;
	localparam logic [7:0] CMD_SET_LEDS  = 8'hED;
	localparam logic [7:0] CMD_TYPEMATIC = 8'hF3;
	localparam logic [7:0] CMD_ENABLE    = 8'hF4;
	localparam logic [7:0] CMD_DEFAULT   = 8'hF6;

	localparam logic [7:0] RSP_ECHO      = 8'hEE;
	localparam logic [7:0] RSP_ACK       = 8'hFA;
	localparam logic [7:0] RSP_ID0       = 8'hAB;
	localparam logic [7:0] RSP_ID1       = 8'h83;
	localparam logic [7:0] RSP_BAT_OK    = 8'hAA;
	localparam logic [7:0] RSP_SCAN_SET  = 8'h02;

	localparam logic [1:0] DELAY_RESET   = 2'd2;
	localparam logic [1:0] DELAY_DEFAULT = 2'd1;
	localparam logic [5:0] RATE_DEFAULT  = 6'd5;

	typedef struct packed {
		logic       req_type;
		logic [7:0] host_byte;
	} req_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] last_byte_sent;
		logic [2:0] led_store;
		logic [1:0] delay_store;
		logic [5:0] rate_store;
	} kbd_state_t;

	typedef struct packed {
		logic       send_valid;
		logic [7:0] send_byte;
		logic       key_slot;
		logic [2:0] led_bits;
		logic [1:0] repeat_delay;
		logic [5:0] repeat_rate;
		logic       enable_pulse;
		logic       clear_pulse;
	} rsp_t;

endpackage

@@ rtl/khcr_if.sv @@
interface khcr_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] host_byte;

	modport source (output valid, output req_type, output host_byte, input ready);
	modport sink   (input valid, input req_type, input host_byte, output ready);
endinterface

interface khcr_rsp_if;
	logic       valid;
	logic       ready;
	logic       send_valid;
	logic [7:0] send_byte;
	logic       key_slot;
	logic [2:0] led_bits;
	logic [1:0] repeat_delay;
	logic [5:0] repeat_rate;
	logic       enable_pulse;
	logic       clear_pulse;

	modport source (
		output valid, output send_valid, output send_byte, output key_slot,
		output led_bits, output repeat_delay, output repeat_rate,
		output enable_pulse, output clear_pulse, input ready
	);
	modport sink (
		input valid, input send_valid, input send_byte, input key_slot,
		input led_bits, input repeat_delay, input repeat_rate,
		input enable_pulse, input clear_pulse, output ready
	);
endinterface

@@ rtl/khcr_decode.sv @@
module khcr_decode (
	input  khcr_pkg::req_t       req,
	input  khcr_pkg::kbd_state_t cur,
	output khcr_pkg::kbd_state_t nxt,
	output khcr_pkg::rsp_t       rsp
);
	import khcr_pkg::*;

	logic [7:0] b;
	logic [5:0] auto_rate;

	assign b = req.host_byte;
	// repeat value: low three bits shifted by bits 4:3, fits in six bits
	assign auto_rate = {3'b000, b[2:0]} << b[4:3];

	always_comb begin
		logic       snd;
		logic [7:0] sbyte;
		logic       remember;
		mode_t      nmode;

		nxt = cur;
		snd = 1'b0;
		sbyte = 8'h00;
		remember = 1'b1;
		nmode = cur.mode;
		rsp = '0;

		if (req.req_type == REQ_HOST_BYTE) begin
			snd = 1'b1;
			sbyte = RSP_ACK;
			nmode = MODE_NORMAL;
			case (cur.mode)
				MODE_SCAN_SET: begin
					rsp.clear_pulse = 1'b1;
					if (b == 8'h00) begin
						nmode = MODE_SCAN_REPLY;
					end
				end
				MODE_WAIT_LEDS: begin
					nxt.led_store = b[2:0];
				end
				MODE_WAIT_AUTO: begin
					nxt.delay_store = b[6:5];
					nxt.rate_store = auto_rate;
				end
				default: begin
					case (b)
						CMD_ECHO: begin
							sbyte = RSP_ECHO;
							nmode = cur.mode;
						end
						CMD_READ_ID:   nmode = MODE_WAIT_ID;
						CMD_RESET:     nmode = MODE_WAIT_RESET;
						CMD_RESEND: begin
							sbyte = cur.last_byte_sent;
							remember = 1'b0;
							nmode = cur.mode;
						end
						CMD_SCAN_SET:  nmode = MODE_SCAN_SET;
						CMD_SET_LEDS:  nmode = MODE_WAIT_LEDS;
						CMD_TYPEMATIC: nmode = MODE_WAIT_AUTO;
						CMD_ENABLE:    rsp.enable_pulse = 1'b1;
						CMD_DEFAULT: begin
							nxt.delay_store = DELAY_DEFAULT;
							nxt.rate_store = RATE_DEFAULT;
							rsp.clear_pulse = 1'b1;
						end
						default: ;
					endcase
				end
			endcase
		end else begin
			case (cur.mode)
				MODE_NORMAL: rsp.key_slot = 1'b1;
				MODE_SCAN_REPLY: begin
					snd = 1'b1;
					sbyte = RSP_SCAN_SET;
					nmode = MODE_NORMAL;
				end
				MODE_WAIT_ID: begin
					snd = 1'b1;
					sbyte = RSP_ID0;
					nmode = MODE_WAIT_ID1;
				end
				MODE_WAIT_ID1: begin
					snd = 1'b1;
					sbyte = RSP_ID1;
					nmode = MODE_NORMAL;
				end
				MODE_WAIT_RESET: begin
					snd = 1'b1;
					sbyte = RSP_BAT_OK;
					nmode = MODE_NORMAL;
					rsp.clear_pulse = 1'b1;
				end
				default: ;
			endcase
		end

		nxt.mode = nmode;
		if (snd && remember) begin
			nxt.last_byte_sent = sbyte;
		end

		rsp.send_valid = snd;
		rsp.send_byte = sbyte;
		rsp.led_bits = nxt.led_store;
		rsp.repeat_delay = nxt.delay_store;
		rsp.repeat_rate = nxt.rate_store;
	end

endmodule

@@ rtl/keyboard_host_command_responder_unit.sv @@
// keyboard host command responder, device side of the ps/2 command exchange
// req channel: one word per host byte (req_type 0) or free transmit slot
//   (req_type 1); host_byte is looked at only for host bytes
// rsp channel: exactly one word per request: the reply byte if any, whether
//   the slot goes to the key stream, the current led and typematic values,
//   and the enable and clear pulses
// datapath: a request word is taken into the input register, decoded there
//   against the current state and loaded into the output register, from which
//   its response is offered
// throughput: one word per cycle unless stalled; mode and stored values update at
//   the same edge that loads the output register, so the next request sees them
// reset: arst_n clears both valid flags and sets the state to waiting for
//   the reset reply, leds zero, delay two, repeat five, last byte zero
// stall: while a response waits and rsp.ready is low, the input register
//   holds one more word and req.ready drops; nothing is lost or repeated
module keyboard_host_command_responder_unit (
	input  logic            clk,
	input  logic            arst_n,
	khcr_req_if.sink        req,
	khcr_rsp_if.source      rsp
);
	import khcr_pkg::*;

	logic       valid_s1;
	req_t       req_s1;
	logic       valid_s2;
	rsp_t       rsp_s2;
	kbd_state_t state_q;
	kbd_state_t state_nxt;
	rsp_t       rsp_nxt;
	logic       adv_s2;
	logic       adv_s1;

	assign adv_s2 = !valid_s2 || rsp.ready;
	assign adv_s1 = valid_s1 && adv_s2;
	assign req.ready = !valid_s1 || adv_s2;

	khcr_decode u_decode (
		.req (req_s1),
		.cur (state_q),
		.nxt (state_nxt),
		.rsp (rsp_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q.mode <= MODE_WAIT_RESET;
			state_q.last_byte_sent <= 8'h00;
			state_q.led_store <= 3'd0;
			state_q.delay_store <= DELAY_RESET;
			state_q.rate_store <= RATE_DEFAULT;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1.req_type <= req.req_type;
			req_s1.host_byte <= req.host_byte;
		end
		if (adv_s1) begin
			rsp_s2 <= rsp_nxt;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.send_valid = rsp_s2.send_valid;
	assign rsp.send_byte = rsp_s2.send_byte;
	assign rsp.key_slot = rsp_s2.key_slot;
	assign rsp.led_bits = rsp_s2.led_bits;
	assign rsp.repeat_delay = rsp_s2.repeat_delay;
	assign rsp.repeat_rate = rsp_s2.repeat_rate;
	assign rsp.enable_pulse = rsp_s2.enable_pulse;
	assign rsp.clear_pulse = rsp_s2.clear_pulse;

endmodule
